[rtl/tgd_pkg.sv]
package tgd_pkg;

    // Field widths
    localparam int POS_W      = 12;
    localparam int DT_W       = 20;
    localparam int HOLD_W     = 32;
    localparam int CLOCK_W    = 40;
    localparam int DIST_W     = 12;
    localparam int INTERVAL_W = 24;
    localparam int CFG_W      = 24;
    localparam int CFG_IDX_W  = 1;

    // Squared distance widths: a 13 bit signed delta squares into 24 bits
    localparam int DELTA_W = POS_W + 1;
    localparam int SQ_W    = 2 * POS_W;
    localparam int D2_W    = SQ_W + 1;
    localparam int LIM_W   = 2 * DIST_W;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DT_MAX_DIST = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DT_INTERVAL = 1'b1;

    // Register reset values
    localparam logic [DIST_W-1:0]     DT_MAX_DIST_RESET = 12'd10;
    localparam logic [INTERVAL_W-1:0] DT_INTERVAL_RESET = 24'd250000;

    // Event codes
    typedef enum logic [1:0] {
        SWIPE_NONE    = 2'd0,
        SWIPE_PRESS   = 2'd1,
        SWIPE_REPEAT  = 2'd2,
        SWIPE_RELEASE = 2'd3
    } swipe_ev_t;

    typedef enum logic [1:0] {
        TAP_NONE    = 2'd0,
        TAP_PRESS   = 2'd1,
        TAP_RELEASE = 2'd2
    } tap_ev_t;

    typedef enum logic [1:0] {
        PINCH_NONE    = 2'd0,
        PINCH_PRESS   = 2'd1,
        PINCH_REPEAT  = 2'd2,
        PINCH_RELEASE = 2'd3
    } pinch_ev_t;

    // One frame tick as held in the input register
    typedef struct packed {
        logic             first_touch_down;
        logic             second_touch_down;
        logic [POS_W-1:0] first_x;
        logic [POS_W-1:0] first_y;
        logic [POS_W-1:0] second_x;
        logic [POS_W-1:0] second_y;
        logic [DT_W-1:0]  tick_time_us;
    } tgd_item_t;

    // Saturating add of a tick time onto a hold timer
    function automatic logic [HOLD_W-1:0] sat_add(input logic [HOLD_W-1:0] a,
                                                  input logic [DT_W-1:0] b);
        logic [HOLD_W:0] sum;
        sum = {1'b0, a} + {{(HOLD_W + 1 - DT_W){1'b0}}, b};
        sat_add = sum[HOLD_W] ? {HOLD_W{1'b1}} : sum[HOLD_W-1:0];
    endfunction

endpackage

[rtl/tgd_in_reg.sv]
module tgd_in_reg
    import tgd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  tgd_item_t in_item,
    output logic      item_valid,
    output tgd_item_t item,
    input  logic      item_take
);

    logic      full_reg;
    logic      full_next;
    tgd_item_t item_reg;
    logic      accept;

    // Input holds one tick; it frees up in the same cycle the engine takes it
    assign in_stall = full_reg && !item_take;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        full_next = full_reg;
        if (accept)
        begin
            full_next = 1'b1;
        end
        else if (item_take)
        begin
            full_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
        end
        else
        begin
            full_reg <= full_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = full_reg;
    assign item       = item_reg;

endmodule

[rtl/tgd_engine.sv]
module tgd_engine
    import tgd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 item_valid,
    input  tgd_item_t            item,
    output logic                 item_take,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [1:0]           swipe_event,
    output logic [1:0]           tap_event,
    output logic                 double_tap_fired,
    output logic [1:0]           pinch_event,
    output logic [POS_W-1:0]     report_first_x,
    output logic [POS_W-1:0]     report_first_y,
    output logic [POS_W-1:0]     report_second_x,
    output logic [POS_W-1:0]     report_second_y,
    output logic [HOLD_W-1:0]    single_hold_us,
    output logic [HOLD_W-1:0]    dual_hold_us
);

    // Configuration; the squared limit is formed when the distance is written
    logic [INTERVAL_W-1:0] interval_reg;
    logic [LIM_W-1:0]      lim_sq_reg;

    // Gesture state
    logic                  prev_first_reg, prev_first_next;
    logic                  prev_both_reg, prev_both_next;
    logic [HOLD_W-1:0]     single_hold_reg, single_hold_next;
    logic [HOLD_W-1:0]     dual_hold_reg, dual_hold_next;
    logic                  swipe_held_reg, swipe_held_next;
    logic                  tap_held_reg, tap_held_next;
    logic                  pinch_held_reg, pinch_held_next;
    logic [POS_W-1:0]      tap_x_reg, tap_x_next;
    logic [POS_W-1:0]      tap_y_reg, tap_y_next;
    logic [CLOCK_W-1:0]    last_tap_reg, last_tap_next;
    logic                  last_tap_valid_reg, last_tap_valid_next;
    logic [CLOCK_W-1:0]    clock_reg, clock_next;

    // Result register
    logic                  out_valid_reg, out_valid_next;
    swipe_ev_t             swipe_reg, swipe_next;
    tap_ev_t               tap_reg, tap_next;
    logic                  dbl_reg, dbl_next;
    pinch_ev_t             pinch_reg, pinch_next;
    logic [POS_W-1:0]      rep_x0_reg, rep_y0_reg, rep_x1_reg, rep_y1_reg;
    logic [HOLD_W-1:0]     single_rep_reg, single_rep_next;
    logic [HOLD_W-1:0]     dual_rep_reg, dual_rep_next;

    // Datapath terms
    logic                  both;
    logic                  first_press;
    logic [HOLD_W-1:0]     single_base;
    logic signed [DELTA_W-1:0] dx, dy;
    logic signed [2*DELTA_W-1:0] dx_sq, dy_sq;
    logic [D2_W-1:0]       d2;
    logic [CLOCK_W-1:0]    gap;
    logic                  tap_qualifies;
    logic                  dbl_hit;

    // A tick moves on when the result register is empty or being drained
    assign item_take = item_valid && (!out_valid_reg || !out_stall);

    // Distance and spacing checks for the double tap
    assign both        = item.first_touch_down && item.second_touch_down;
    assign first_press = item.first_touch_down && !prev_first_reg;
    assign clock_next  = clock_reg + {{(CLOCK_W - DT_W){1'b0}}, item.tick_time_us};
    assign dx    = $signed({1'b0, tap_x_reg}) - $signed({1'b0, item.first_x});
    assign dy    = $signed({1'b0, tap_y_reg}) - $signed({1'b0, item.first_y});
    assign dx_sq = dx * dx;
    assign dy_sq = dy * dy;
    assign d2    = {1'b0, dx_sq[SQ_W-1:0]} + {1'b0, dy_sq[SQ_W-1:0]};
    assign gap   = clock_next - last_tap_reg;
    assign tap_qualifies = !item.first_touch_down && prev_first_reg && tap_held_reg
                           && (single_hold_reg < {{(HOLD_W - INTERVAL_W){1'b0}}, interval_reg});
    assign dbl_hit = last_tap_valid_reg
                     && (gap < {{(CLOCK_W - INTERVAL_W){1'b0}}, interval_reg})
                     && (d2 < {1'b0, lim_sq_reg});
    assign single_base = first_press ? '0 : single_hold_reg;

    // One contact: swipe and tap
    always_comb
    begin
        swipe_next          = SWIPE_NONE;
        tap_next            = TAP_NONE;
        dbl_next            = 1'b0;
        single_hold_next    = single_hold_reg;
        single_rep_next     = single_hold_reg;
        tap_x_next          = tap_x_reg;
        tap_y_next          = tap_y_reg;
        last_tap_next       = last_tap_reg;
        last_tap_valid_next = last_tap_valid_reg;
        if (item.first_touch_down)
        begin
            if (swipe_held_reg)
            begin
                swipe_next = SWIPE_REPEAT;
            end
            else if (first_press)
            begin
                swipe_next = SWIPE_PRESS;
            end
            if (first_press)
            begin
                tap_next   = TAP_PRESS;
                tap_x_next = item.first_x;
                tap_y_next = item.first_y;
            end
            single_rep_next  = single_base;
            single_hold_next = sat_add(single_base, item.tick_time_us);
        end
        else if (prev_first_reg)
        begin
            if (swipe_held_reg)
            begin
                swipe_next = SWIPE_RELEASE;
            end
            if (tap_qualifies)
            begin
                if (dbl_hit)
                begin
                    dbl_next            = 1'b1;
                    last_tap_valid_next = 1'b0;
                end
                else
                begin
                    last_tap_next       = clock_next;
                    last_tap_valid_next = 1'b1;
                end
                tap_next   = TAP_RELEASE;
                tap_x_next = item.first_x;
                tap_y_next = item.first_y;
            end
        end
    end

    // Two contacts: pinch
    always_comb
    begin
        pinch_next     = PINCH_NONE;
        dual_hold_next = dual_hold_reg;
        dual_rep_next  = dual_hold_reg;
        if (both)
        begin
            if (!prev_both_reg)
            begin
                pinch_next    = PINCH_PRESS;
                dual_rep_next = '0;
            end
            else if (pinch_held_reg)
            begin
                pinch_next = PINCH_REPEAT;
            end
            dual_hold_next = sat_add(dual_rep_next, item.tick_time_us);
        end
        else if (prev_both_reg && pinch_held_reg)
        begin
            pinch_next = PINCH_RELEASE;
        end
    end

    // Held flags follow the events of this tick
    always_comb
    begin
        prev_first_next = item.first_touch_down;
        prev_both_next  = both;
        swipe_held_next = swipe_held_reg;
        tap_held_next   = tap_held_reg;
        pinch_held_next = pinch_held_reg;
        if (swipe_next == SWIPE_PRESS)
        begin
            swipe_held_next = 1'b1;
        end
        else if (swipe_next == SWIPE_RELEASE)
        begin
            swipe_held_next = 1'b0;
        end
        if (tap_next == TAP_PRESS)
        begin
            tap_held_next = 1'b1;
        end
        else if (tap_next == TAP_RELEASE)
        begin
            tap_held_next = 1'b0;
        end
        if (pinch_next == PINCH_PRESS)
        begin
            pinch_held_next = 1'b1;
        end
        else if (pinch_next == PINCH_RELEASE)
        begin
            pinch_held_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (item_take)
        begin
            out_valid_next = 1'b1;
        end
    end

    // Control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg       <= DT_INTERVAL_RESET;
            lim_sq_reg         <= LIM_W'(DT_MAX_DIST_RESET) * LIM_W'(DT_MAX_DIST_RESET);
            prev_first_reg     <= 1'b0;
            prev_both_reg      <= 1'b0;
            single_hold_reg    <= '0;
            dual_hold_reg      <= '0;
            swipe_held_reg     <= 1'b0;
            tap_held_reg       <= 1'b0;
            pinch_held_reg     <= 1'b0;
            tap_x_reg          <= '0;
            tap_y_reg          <= '0;
            last_tap_reg       <= '0;
            last_tap_valid_reg <= 1'b0;
            clock_reg          <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_DT_MAX_DIST:
                    begin
                        lim_sq_reg <= LIM_W'(cfg_data[DIST_W-1:0])
                                      * LIM_W'(cfg_data[DIST_W-1:0]);
                    end
                    CFG_DT_INTERVAL:
                    begin
                        interval_reg <= cfg_data[INTERVAL_W-1:0];
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (item_take)
            begin
                prev_first_reg     <= prev_first_next;
                prev_both_reg      <= prev_both_next;
                single_hold_reg    <= single_hold_next;
                dual_hold_reg      <= dual_hold_next;
                swipe_held_reg     <= swipe_held_next;
                tap_held_reg       <= tap_held_next;
                pinch_held_reg     <= pinch_held_next;
                tap_x_reg          <= tap_x_next;
                tap_y_reg          <= tap_y_next;
                last_tap_reg       <= last_tap_next;
                last_tap_valid_reg <= last_tap_valid_next;
                clock_reg          <= clock_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload, no reset
    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            swipe_reg      <= swipe_next;
            tap_reg        <= tap_next;
            dbl_reg        <= dbl_next;
            pinch_reg      <= pinch_next;
            rep_x0_reg     <= item.first_x;
            rep_y0_reg     <= item.first_y;
            rep_x1_reg     <= item.second_x;
            rep_y1_reg     <= item.second_y;
            single_rep_reg <= single_rep_next;
            dual_rep_reg   <= dual_rep_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign swipe_event      = swipe_reg;
    assign tap_event        = tap_reg;
    assign double_tap_fired = dbl_reg;
    assign pinch_event      = pinch_reg;
    assign report_first_x   = rep_x0_reg;
    assign report_first_y   = rep_y0_reg;
    assign report_second_x  = rep_x1_reg;
    assign report_second_y  = rep_y1_reg;
    assign single_hold_us   = single_rep_reg;
    assign dual_hold_us     = dual_rep_reg;

`ifndef ASSERT_OFF
    // A double tap only rides on a tap release
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && dbl_reg |-> tap_reg == TAP_RELEASE)
        else $error("double tap without tap release");

    // Press ticks report a cleared hold time
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && swipe_reg == SWIPE_PRESS |-> single_rep_reg == '0)
        else $error("swipe press with nonzero hold");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && pinch_reg == PINCH_PRESS |-> dual_rep_reg == '0)
        else $error("pinch press with nonzero hold");

    // A taken tick always shows up in the result register next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        item_take |=> out_valid_reg)
        else $error("taken tick lost");

    // A double tap consumes the recorded tap
    assert property (@(posedge clk) disable iff (!rst_n)
        item_take && dbl_next |=> !last_tap_valid_reg)
        else $error("tap record kept after double tap");
`endif

endmodule

[rtl/touch_gesture_detector_unit.sv]
// Touch gesture detector: takes one frame tick per transfer (two contact flags and
// positions plus elapsed microseconds) and returns one result per tick with swipe,
// tap, double tap and pinch events, the current positions and the hold times before
// the tick. A tick passes the input register, then the gesture update into the
// result register. A new tick can be taken every cycle unless out_stall holds back
// a full result; the single gesture update stage sets that rate. Registers are written
// through cfg_we/cfg_index/cfg_data; the user must write them only while no tick is in
// flight, which the block does not enforce: index 0 is the double tap distance limit
// in pixels, index 1 the tap hold limit and double tap spacing in microseconds.
module touch_gesture_detector_unit
    import tgd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 first_touch_down,
    input  logic                 second_touch_down,
    input  logic [POS_W-1:0]     first_x,
    input  logic [POS_W-1:0]     first_y,
    input  logic [POS_W-1:0]     second_x,
    input  logic [POS_W-1:0]     second_y,
    input  logic [DT_W-1:0]      tick_time_us,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [1:0]           swipe_event,
    output logic [1:0]           tap_event,
    output logic                 double_tap_fired,
    output logic [1:0]           pinch_event,
    output logic [POS_W-1:0]     report_first_x,
    output logic [POS_W-1:0]     report_first_y,
    output logic [POS_W-1:0]     report_second_x,
    output logic [POS_W-1:0]     report_second_y,
    output logic [HOLD_W-1:0]    single_hold_us,
    output logic [HOLD_W-1:0]    dual_hold_us
);

    tgd_item_t in_item;
    tgd_item_t item;
    logic      item_valid;
    logic      item_take;

    // Gather the input fields into one tick
    always_comb
    begin
        in_item.first_touch_down  = first_touch_down;
        in_item.second_touch_down = second_touch_down;
        in_item.first_x           = first_x;
        in_item.first_y           = first_y;
        in_item.second_x          = second_x;
        in_item.second_y          = second_y;
        in_item.tick_time_us      = tick_time_us;
    end

    tgd_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    tgd_engine u_engine (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .item_valid       (item_valid),
        .item             (item),
        .item_take        (item_take),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .swipe_event      (swipe_event),
        .tap_event        (tap_event),
        .double_tap_fired (double_tap_fired),
        .pinch_event      (pinch_event),
        .report_first_x   (report_first_x),
        .report_first_y   (report_first_y),
        .report_second_x  (report_second_x),
        .report_second_y  (report_second_y),
        .single_hold_us   (single_hold_us),
        .dual_hold_us     (dual_hold_us)
    );

endmodule

[test/tb_touch_gesture_detector_unit.sv]
`timescale 1ns / 1ps

module tb_touch_gesture_detector_unit;
    import tgd_pkg::*;

    localparam int SETTLE_CYCLES = 4;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int MAX_REPORTS = 200;
    localparam int LONG_HOLD_TICKS = 20;
    localparam logic [DT_W-1:0] DT_MAX = {DT_W{1'b1}};

    // One expected result per tick
    typedef struct packed {
        swipe_ev_t         swipe;
        tap_ev_t           tap;
        logic              dbl;
        pinch_ev_t         pinch;
        logic [POS_W-1:0]  fx;
        logic [POS_W-1:0]  fy;
        logic [POS_W-1:0]  sx;
        logic [POS_W-1:0]  sy;
        logic [HOLD_W-1:0] single_hold;
        logic [HOLD_W-1:0] dual_hold;
    } gesture_result_t;

    logic                 clk;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic                 first_touch_down = 1'b0;
    logic                 second_touch_down = 1'b0;
    logic [POS_W-1:0]     first_x = '0;
    logic [POS_W-1:0]     first_y = '0;
    logic [POS_W-1:0]     second_x = '0;
    logic [POS_W-1:0]     second_y = '0;
    logic [DT_W-1:0]      tick_time_us = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [1:0]           swipe_event;
    logic [1:0]           tap_event;
    logic                 double_tap_fired;
    logic [1:0]           pinch_event;
    logic [POS_W-1:0]     report_first_x;
    logic [POS_W-1:0]     report_first_y;
    logic [POS_W-1:0]     report_second_x;
    logic [POS_W-1:0]     report_second_y;
    logic [HOLD_W-1:0]    single_hold_us;
    logic [HOLD_W-1:0]    dual_hold_us;

    touch_gesture_detector_unit u_top (.*);

    // Gesture tracker copy: configuration and state
    logic [DIST_W-1:0]     trk_max_dist = DT_MAX_DIST_RESET;
    logic [INTERVAL_W-1:0] trk_interval = DT_INTERVAL_RESET;
    logic                  trk_prev_first = 1'b0;
    logic                  trk_prev_both = 1'b0;
    logic [HOLD_W-1:0]     trk_single_hold = '0;
    logic [HOLD_W-1:0]     trk_dual_hold = '0;
    logic                  trk_swipe_held = 1'b0;
    logic                  trk_tap_held = 1'b0;
    logic                  trk_pinch_held = 1'b0;
    logic [POS_W-1:0]      trk_tap_x = '0;
    logic [POS_W-1:0]      trk_tap_y = '0;
    logic [CLOCK_W-1:0]    trk_last_tap_us = '0;
    logic                  trk_last_tap_ok = 1'b0;
    logic [CLOCK_W-1:0]    trk_clock_us = '0;

    gesture_result_t pending_gestures[$];
    int err_count = 0;
    int ticks_sent = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int cycle_count = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb_touch_gesture_detector_unit: errors");
        $finish;
    end

    // Receiver back-pressure
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    function automatic logic [HOLD_W-1:0] hold_add(input logic [HOLD_W-1:0] a,
                                                   input logic [DT_W-1:0] b);
        logic [HOLD_W:0] s;
        s = {1'b0, a} + {{(HOLD_W + 1 - DT_W){1'b0}}, b};
        return s[HOLD_W] ? {HOLD_W{1'b1}} : s[HOLD_W-1:0];
    endfunction

    // Advance the tracker by one tick and queue the result it gives
    task automatic track_tick(input tgd_item_t t);
        gesture_result_t r;
        logic both;
        int dx;
        int dy;
        longint unsigned d2;
        longint unsigned lim;
        logic [CLOCK_W-1:0] gap;
        both = t.first_touch_down & t.second_touch_down;
        r.swipe = SWIPE_NONE;
        r.tap = TAP_NONE;
        r.dbl = 1'b0;
        r.pinch = PINCH_NONE;
        r.fx = t.first_x;
        r.fy = t.first_y;
        r.sx = t.second_x;
        r.sy = t.second_y;
        trk_clock_us = trk_clock_us + CLOCK_W'(t.tick_time_us);

        // one contact: swipe and tap
        if (t.first_touch_down)
        begin
            if (!trk_prev_first)
            begin
                trk_single_hold = '0;
                r.tap = TAP_PRESS;
                trk_tap_x = t.first_x;
                trk_tap_y = t.first_y;
            end
            if (trk_swipe_held)
                r.swipe = SWIPE_REPEAT;
            else if (!trk_prev_first)
                r.swipe = SWIPE_PRESS;
            r.single_hold = trk_single_hold;
            trk_single_hold = hold_add(trk_single_hold, t.tick_time_us);
        end
        else
        begin
            r.single_hold = trk_single_hold;
            if (trk_prev_first)
            begin
                if (trk_swipe_held)
                    r.swipe = SWIPE_RELEASE;
                // short hold only; long hold leaves the tap mark set
                if (trk_tap_held && trk_single_hold < HOLD_W'(trk_interval))
                begin
                    dx = int'(trk_tap_x) - int'(t.first_x);
                    dy = int'(trk_tap_y) - int'(t.first_y);
                    d2 = 64'(dx * dx + dy * dy);
                    lim = 64'(trk_max_dist) * 64'(trk_max_dist);
                    gap = trk_clock_us - trk_last_tap_us;
                    if (trk_last_tap_ok && gap < CLOCK_W'(trk_interval) && d2 < lim)
                    begin
                        r.dbl = 1'b1;
                        trk_last_tap_ok = 1'b0;
                    end
                    else
                    begin
                        trk_last_tap_us = trk_clock_us;
                        trk_last_tap_ok = 1'b1;
                    end
                    r.tap = TAP_RELEASE;
                    trk_tap_x = t.first_x;
                    trk_tap_y = t.first_y;
                end
            end
        end

        // two contacts: pinch
        if (both)
        begin
            if (!trk_prev_both)
            begin
                trk_dual_hold = '0;
                r.pinch = PINCH_PRESS;
            end
            else if (trk_pinch_held)
            begin
                r.pinch = PINCH_REPEAT;
            end
            r.dual_hold = trk_dual_hold;
            trk_dual_hold = hold_add(trk_dual_hold, t.tick_time_us);
        end
        else
        begin
            r.dual_hold = trk_dual_hold;
            if (trk_prev_both && trk_pinch_held)
                r.pinch = PINCH_RELEASE;
        end

        trk_prev_first = t.first_touch_down;
        trk_prev_both = both;

        // held marks follow the events formed above
        if (r.swipe == SWIPE_PRESS)
            trk_swipe_held = 1'b1;
        else if (r.swipe == SWIPE_RELEASE)
            trk_swipe_held = 1'b0;
        if (r.tap == TAP_PRESS)
            trk_tap_held = 1'b1;
        else if (r.tap == TAP_RELEASE)
            trk_tap_held = 1'b0;
        if (r.pinch == PINCH_PRESS)
            trk_pinch_held = 1'b1;
        else if (r.pinch == PINCH_RELEASE)
            trk_pinch_held = 1'b0;

        pending_gestures.push_back(r);
    endtask

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (got !== want)
        begin
            if (err_count < MAX_REPORTS)
                $display("%0t: %s expected %0h got %0h", $time, name, want, got);
            err_count++;
        end
    endfunction

    // Result checker: sampled at the falling edge, away from the driving edge
    always @(negedge clk)
    begin : result_check
        gesture_result_t want;
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (pending_gestures.size() == 0)
            begin
                if (err_count < MAX_REPORTS)
                    $display("%0t: result transfer with no tick pending", $time);
                err_count++;
            end
            else
            begin
                want = pending_gestures.pop_front();
                check_field("swipe_event", want.swipe, swipe_event);
                check_field("tap_event", want.tap, tap_event);
                check_field("double_tap_fired", want.dbl, double_tap_fired);
                check_field("pinch_event", want.pinch, pinch_event);
                check_field("report_first_x", want.fx, report_first_x);
                check_field("report_first_y", want.fy, report_first_y);
                check_field("report_second_x", want.sx, report_second_x);
                check_field("report_second_y", want.sy, report_second_y);
                check_field("single_hold_us", want.single_hold, single_hold_us);
                check_field("dual_hold_us", want.dual_hold, dual_hold_us);
            end
        end
    end

    function automatic tgd_item_t make_tick(input logic d0, input logic d1,
                                            input logic [POS_W-1:0] x0,
                                            input logic [POS_W-1:0] y0,
                                            input logic [POS_W-1:0] x1,
                                            input logic [POS_W-1:0] y1,
                                            input logic [DT_W-1:0] dt);
        tgd_item_t t;
        t.first_touch_down = d0;
        t.second_touch_down = d1;
        t.first_x = x0;
        t.first_y = y0;
        t.second_x = x1;
        t.second_y = y1;
        t.tick_time_us = dt;
        return t;
    endfunction

    function automatic logic [POS_W-1:0] rand_pos();
        return POS_W'($urandom);
    endfunction

    // Small random move, clamped to the panel
    function automatic logic [POS_W-1:0] nudge(input logic [POS_W-1:0] v);
        int p;
        p = int'(v) + int'($urandom_range(0, 30)) - 15;
        if (p < 0)
            p = 0;
        if (p > 4095)
            p = 4095;
        return POS_W'(p);
    endfunction

    // Tick time: mostly short against the tap interval, some full range
    function automatic logic [DT_W-1:0] pick_dt();
        int unsigned sel;
        int unsigned cap;
        sel = $urandom_range(99);
        cap = 32'(trk_interval) / 4;
        if (cap > 32'(DT_MAX))
            cap = 32'(DT_MAX);
        if (sel < 10)
            return DT_W'($urandom);
        else if (sel < 30)
            return DT_W'($urandom_range(0, 200));
        return DT_W'($urandom_range(0, cap));
    endfunction

    // Send one tick; called at a rising edge, returns at the accepting edge
    task automatic send_tick(input tgd_item_t t);
        logic taken;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        first_touch_down <= t.first_touch_down;
        second_touch_down <= t.second_touch_down;
        first_x <= t.first_x;
        first_y <= t.first_y;
        second_x <= t.second_x;
        second_y <= t.second_y;
        tick_time_us <= t.tick_time_us;
        do
        begin
            @(negedge clk);
            taken = (in_stall === 1'b0);
            @(posedge clk);
        end
        while (!taken);
        track_tick(t);
        ticks_sent++;
    endtask

    // Hold off the sender until every result is back
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_gestures.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_index <= idx;
        cfg_data <= data;
        cfg_we <= 1'b1;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_DT_MAX_DIST)
            trk_max_dist = data[DIST_W-1:0];
        else if (idx == CFG_DT_INTERVAL)
            trk_interval = data[INTERVAL_W-1:0];
        @(posedge clk);
    endtask

    task automatic set_config(input logic [DIST_W-1:0] max_dist,
                              input logic [INTERVAL_W-1:0] interval);
        wait_drained();
        write_reg(CFG_DT_MAX_DIST, CFG_W'(max_dist));
        write_reg(CFG_DT_INTERVAL, CFG_W'(interval));
    endtask

    // One random gesture: taps, swipe, pinch or noise
    task automatic send_gesture_burst();
        int unsigned pick;
        int len;
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
        logic [POS_W-1:0] x2;
        logic [POS_W-1:0] y2;
        pick = $urandom_range(9);
        x = rand_pos();
        y = rand_pos();
        x2 = rand_pos();
        y2 = rand_pos();
        if (pick < 4)
        begin
            // tap run, often close enough for a double tap
            repeat ($urandom_range(1, 3))
            begin
                send_tick(make_tick(1'b1, 1'b0, x, y, x2, y2, pick_dt()));
                repeat ($urandom_range(0, 2))
                    send_tick(make_tick(1'b1, 1'b0, nudge(x), nudge(y), x2, y2, pick_dt()));
                send_tick(make_tick(1'b0, 1'b0, nudge(x), nudge(y), x2, y2, pick_dt()));
                if ($urandom_range(1))
                    send_tick(make_tick(1'b0, 1'b0, x, y, x2, y2, pick_dt()));
            end
        end
        else if (pick < 6)
        begin
            // swipe drag
            len = $urandom_range(1, 8);
            send_tick(make_tick(1'b1, 1'b0, x, y, x2, y2, pick_dt()));
            repeat (len)
            begin
                x = nudge(x);
                y = nudge(y);
                send_tick(make_tick(1'b1, 1'b0, x, y, x2, y2, pick_dt()));
            end
            send_tick(make_tick(1'b0, 1'b0, x, y, x2, y2, pick_dt()));
        end
        else if (pick < 8)
        begin
            // pinch, with the contacts landing and lifting in varied order
            if ($urandom_range(1))
                send_tick(make_tick(1'b1, 1'b0, x, y, x2, y2, pick_dt()));
            if ($urandom_range(3) == 0)
                send_tick(make_tick(1'b0, 1'b1, x, y, x2, y2, pick_dt()));
            len = $urandom_range(1, 6);
            send_tick(make_tick(1'b1, 1'b1, x, y, x2, y2, pick_dt()));
            repeat (len)
            begin
                x = nudge(x);
                x2 = nudge(x2);
                send_tick(make_tick(1'b1, 1'b1, x, y, x2, y2, pick_dt()));
            end
            case ($urandom_range(2))
                0: send_tick(make_tick(1'b1, 1'b0, x, y, x2, y2, pick_dt()));
                1: send_tick(make_tick(1'b0, 1'b1, x, y, x2, y2, pick_dt()));
                default: ;
            endcase
            send_tick(make_tick(1'b0, 1'b0, x, y, x2, y2, pick_dt()));
        end
        else
        begin
            // noise over the full field ranges
            repeat ($urandom_range(1, 4))
                send_tick(make_tick(1'($urandom_range(1)), 1'($urandom_range(1)),
                                    rand_pos(), rand_pos(), rand_pos(), rand_pos(),
                                    DT_W'($urandom)));
        end
    endtask

    // Extremes and the named corner cases at reset settings
    task automatic test_directed_gestures();
        // idle tick, then tap at the origin
        send_tick(make_tick(1'b0, 1'b0, 12'd0, 12'd0, 12'd0, 12'd0, 20'd0));
        send_tick(make_tick(1'b1, 1'b0, 12'd0, 12'd0, 12'd0, 12'd0, 20'd0));
        send_tick(make_tick(1'b0, 1'b0, 12'd3, 12'd4, 12'd0, 12'd0, 20'd100));
        // second tap close by: double tap
        send_tick(make_tick(1'b1, 1'b0, 12'd0, 12'd0, 12'd0, 12'd0, 20'd100));
        send_tick(make_tick(1'b0, 1'b0, 12'd3, 12'd4, 12'd0, 12'd0, 20'd100));
        // hold exactly the interval: no tap release, tap mark stays
        send_tick(make_tick(1'b1, 1'b0, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 20'd0));
        send_tick(make_tick(1'b1, 1'b0, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 20'd250000));
        send_tick(make_tick(1'b0, 1'b0, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, DT_MAX));
        // one short of the interval: tap release
        send_tick(make_tick(1'b1, 1'b0, 12'hFFF, 12'hFFF, 12'd0, 12'd0, 20'd0));
        send_tick(make_tick(1'b1, 1'b0, 12'hFFF, 12'hFFF, 12'd0, 12'd0, 20'd249999));
        send_tick(make_tick(1'b0, 1'b0, 12'hFFF, 12'hFFF, 12'd0, 12'd0, 20'd0));
        // second contact alone counts for nothing
        send_tick(make_tick(1'b0, 1'b1, 12'hFFF, 12'd0, 12'hFFF, 12'hFFF, DT_MAX));
        // pinch press, repeat, release by lifting the second contact, press again
        send_tick(make_tick(1'b1, 1'b1, 12'd100, 12'd100, 12'd4000, 12'd4000, 20'd10));
        send_tick(make_tick(1'b1, 1'b1, 12'd90, 12'd90, 12'd3990, 12'd3990, 20'd20));
        send_tick(make_tick(1'b1, 1'b0, 12'd80, 12'd80, 12'd3980, 12'd3980, 20'd30));
        send_tick(make_tick(1'b1, 1'b1, 12'd70, 12'd70, 12'd3970, 12'd3970, 20'd40));
        send_tick(make_tick(1'b0, 1'b0, 12'd70, 12'd70, 12'd3970, 12'd3970, 20'd50));
        // second lands first, then both
        send_tick(make_tick(1'b0, 1'b1, 12'd5, 12'd6, 12'd7, 12'd8, 20'd60));
        send_tick(make_tick(1'b1, 1'b1, 12'd5, 12'd6, 12'd7, 12'd8, 20'd70));
        send_tick(make_tick(1'b0, 1'b0, 12'd5, 12'd6, 12'd7, 12'd8, 20'd80));
    endtask

    task automatic test_random_gestures(input int n_ticks, input logic [DIST_W-1:0] max_dist,
                                        input logic [INTERVAL_W-1:0] interval,
                                        input int send_pct, input int recv_pct,
                                        input bit pause_midway);
        int goal;
        bit paused;
        set_config(max_dist, interval);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        goal = ticks_sent + n_ticks;
        paused = !pause_midway;
        while (ticks_sent < goal)
        begin
            send_gesture_burst();
            if (!paused && ticks_sent >= goal - n_ticks / 2)
            begin
                paused = 1'b1;
                wait_drained();
            end
        end
    endtask

    // Long two-contact hold past the widest interval, so the lift gives no tap
    // release; then a run of taps with varied spacing at the widest limits
    task automatic test_long_hold_taps();
        set_config({DIST_W{1'b1}}, {INTERVAL_W{1'b1}});
        send_idle_pct = 0;
        recv_stall_pct = 0;
        send_tick(make_tick(1'b1, 1'b1, 12'd2000, 12'd2000, 12'd100, 12'd100, 20'd0));
        repeat (LONG_HOLD_TICKS)
            send_tick(make_tick(1'b1, 1'b1, rand_pos(), rand_pos(), rand_pos(), rand_pos(),
                                DT_MAX));
        send_tick(make_tick(1'b0, 1'b0, 12'd2000, 12'd2000, 12'd0, 12'd0, 20'd0));
        send_tick(make_tick(1'b1, 1'b0, 12'd2000, 12'd2000, 12'd0, 12'd0, 20'd500));
        send_tick(make_tick(1'b0, 1'b0, 12'd2001, 12'd2000, 12'd0, 12'd0, 20'd500));
        send_tick(make_tick(1'b1, 1'b0, 12'd2000, 12'd2001, 12'd0, 12'd0, 20'd1500));
        send_tick(make_tick(1'b0, 1'b0, 12'd2000, 12'd2002, 12'd0, 12'd0, 20'd1500));
        send_tick(make_tick(1'b1, 1'b0, 12'd2000, 12'd2000, 12'd0, 12'd0, 20'd700));
        send_tick(make_tick(1'b0, 1'b0, 12'd2000, 12'd2000, 12'd0, 12'd0, 20'd700));
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // sender idles 34%, receiver stalls 58%
        send_idle_pct = 34;
        recv_stall_pct = 58;
        test_directed_gestures();
        test_random_gestures(150, 12'd10, 24'd250000, 34, 58, 1'b1);
        test_random_gestures(150, {DIST_W{1'b1}}, {INTERVAL_W{1'b1}}, 34, 58, 1'b0);
        // roles swapped
        test_random_gestures(100, 12'd0, 24'd0, 58, 34, 1'b0);
        test_random_gestures(150, 12'd25, 24'd60000, 58, 34, 1'b1);
        // full rate
        test_random_gestures(150, {DIST_W{1'b1}}, 24'd1000000, 0, 0, 1'b0);
        test_random_gestures(150, 12'd1, 24'd5000, 0, 0, 1'b0);
        test_long_hold_taps();

        wait_drained();
        repeat (8) @(posedge clk);
        if (err_count == 0)
            $display("tb_touch_gesture_detector_unit: clean");
        else
            $display("tb_touch_gesture_detector_unit: errors");
        $finish;
    end

endmodule
